>>> hdl/assert_macros.svh
// Assertion macros shared by the cipher modules.
// Depends on nothing; bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

>>> hdl/aes128_pkg.sv
// Types, tables and round functions for the AES-128 pipeline.
// Depends on nothing; used by every module in hdl.
package aes128_pkg;
   localparam int NumRounds = 10;
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_LOW = 1'b1;

   // Cycles the registered round-key chain needs to take up a new key.
   localparam int SettleW = 4;
   localparam logic [SettleW-1:0] KEY_SETTLE = 4'd11;

   typedef struct packed {
      logic        mode;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                        8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   // Byte i of a 128-bit state sits in bits 127-8i downto 120-8i.
   function automatic logic [7:0] get_byte(input logic [127:0] s, input logic [3:0] i);
      get_byte = s[8*(15-i) +: 8];
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] x);
      xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Next round key from the previous one and the round constant.
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] t;
      logic [31:0] w0, w1, w2, w3;
      t = {FWD_BOX[k[23:16]] ^ rc, FWD_BOX[k[15:8]], FWD_BOX[k[7:0]], FWD_BOX[k[31:24]]};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      next_key = {w0, w1, w2, w3};
   endfunction

   // One encryption round; the last round skips MixColumns.
   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(15-(4*c+r)) +: 8] = FWD_BOX[s[8*(15-(4*((c+r)%4)+r)) +: 8]];
         end
      end
      enc_round = t;
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[8*(15-4*c) +: 8];
            a1 = t[8*(14-4*c) +: 8];
            a2 = t[8*(13-4*c) +: 8];
            a3 = t[8*(12-4*c) +: 8];
            enc_round[8*(15-4*c) +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            enc_round[8*(14-4*c) +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            enc_round[8*(13-4*c) +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            enc_round[8*(12-4*c) +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
         end
      end
   endfunction

   // InvShiftRows and InvSubBytes of one decryption round.
   function automatic logic [127:0] dec_sub(input logic [127:0] s);
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            dec_sub[8*(15-(4*c+r)) +: 8] = INV_BOX[s[8*(15-(4*((c+4-r)%4)+r)) +: 8]];
         end
      end
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [7:0] a [4];
      logic [7:0] m2 [4];
      logic [7:0] m4 [4];
      logic [7:0] m8 [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a[r] = s[8*(15-(4*c+r)) +: 8];
            m2[r] = xt(a[r]);
            m4[r] = xt(m2[r]);
            m8[r] = xt(m4[r]);
         end
         for (int r = 0; r < 4; r++) begin
            // 14, 11, 13, 9 applied to rows r, r+1, r+2, r+3.
            inv_mix[8*(15-(4*c+r)) +: 8] =
               (m8[r] ^ m4[r] ^ m2[r]) ^
               (m8[(r+1)%4] ^ m2[(r+1)%4] ^ a[(r+1)%4]) ^
               (m8[(r+2)%4] ^ m4[(r+2)%4] ^ a[(r+2)%4]) ^
               (m8[(r+3)%4] ^ a[(r+3)%4]);
         end
      end
   endfunction
endpackage

>>> hdl/aes128_block_cipher.sv
// AES-128 encrypt/decrypt, one pipeline stage per round plus an input key-add stage.
// Each beat passes the key-add stage and then the round stages in order to its result.
// Throughput: one beat per cycle, back to back, except while the round keys settle.
// Busy is high after reset and after every key write, while the registered
// round-key chain takes up the key one round per cycle; the receiver cannot stall.
// Synchronous active-high reset clears the key registers and all valid bits.
`include "assert_macros.svh"
module aes128_block_cipher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  aes128_pkg::req_type         req_data,
   output logic                        rsp_valid,
   output aes128_pkg::rsp_type         rsp_data,
   input  logic                        csr_we,
   input  logic [aes128_pkg::CsrIdxW-1:0] csr_index,
   input  logic [63:0]                 csr_wdata
);
   logic [63:0]  key_high_ff;
   logic [63:0]  key_low_ff;
   logic [127:0] round_keys [11];

   // Counts down the cycles until every round key reflects the held key.
   logic [aes128_pkg::SettleW-1:0] settle_ff;
   logic [aes128_pkg::SettleW-1:0] settle_in;

   // Stage zero: initial AddRoundKey, first key for encryption, last for decryption.
   logic         v0_ff;
   logic         m0_ff;
   logic [127:0] s0_ff;
   logic [127:0] s0_in;

   logic         v [11];
   logic         m [11];
   logic [127:0] s [11];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            aes128_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            aes128_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   aes128_keysched u_keysched (
      .clock      (clock),
      .key        ({key_high_ff, key_low_ff}),
      .round_keys (round_keys)
   );

   // A key write restarts the count; the last round key is good once it reaches zero.
   always_comb begin
      if (csr_we) begin
         settle_in = aes128_pkg::KEY_SETTLE;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= aes128_pkg::KEY_SETTLE;
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign busy = (settle_ff != '0);

   always_comb begin
      s0_in = {req_data.block_high, req_data.block_low} ^
              (req_data.mode ? round_keys[10] : round_keys[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
      m0_ff <= req_data.mode;
      s0_ff <= s0_in;
   end

   assign v[0] = v0_ff;
   assign m[0] = m0_ff;
   assign s[0] = s0_ff;

   // Round r uses key r forward and key 10-r backward.
   for (genvar r = 1; r <= aes128_pkg::NumRounds; r++) begin : g_round
      aes128_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v[r-1]),
         .in_mode   (m[r-1]),
         .in_state  (s[r-1]),
         .enc_key   (round_keys[r]),
         .dec_key   (round_keys[10-r]),
         .last      (r == aes128_pkg::NumRounds),
         .out_valid (v[r]),
         .out_mode  (m[r]),
         .out_state (s[r])
      );
   end

   assign rsp_valid = v[10];
   assign rsp_data  = {s[10][127:64], s[10][63:0]};

   `ASSERT_NEXT(a_write_busy, clock, reset, csr_we, busy)
   `ASSERT_NEXT(a_enter, clock, reset, start && !busy, v[0])
   `ASSERT_NEXT(a_key_hold, clock, reset, !csr_we, key_high_ff == $past(key_high_ff))
endmodule

>>> hdl/aes128_keysched.sv
// Round-key schedule: expands the held key into eleven round keys, one register per key.
// Depends on aes128_pkg.
module aes128_keysched (
   input  logic                clock,
   input  logic [127:0]        key,
   output logic [127:0]        round_keys [11]
);
   // The user must keep keys static while items are in flight, which the block
   // does not enforce; a registered chain suffices, each link one key step deep.
   logic [127:0] rk_ff [11];
   logic [127:0] rk_in [11];

   always_comb begin
      rk_in[0] = key;
      for (int i = 1; i < 11; i++) begin
         rk_in[i] = aes128_pkg::next_key(rk_ff[i-1], aes128_pkg::RCON[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 11; i++) begin
         rk_ff[i] <= rk_in[i];
      end
   end

   assign round_keys = rk_ff;
endmodule

>>> hdl/aes128_round.sv
// One pipeline stage holding one cipher round for either direction.
// Depends on aes128_pkg and assert_macros.svh.
`include "assert_macros.svh"
module aes128_round (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic         in_mode,
   input  logic [127:0] in_state,
   input  logic [127:0] enc_key,
   input  logic [127:0] dec_key,
   input  logic         last,
   output logic         out_valid,
   output logic         out_mode,
   output logic [127:0] out_state
);
   logic         valid_ff;
   logic         mode_ff;
   logic [127:0] state_ff;
   logic [127:0] state_in;
   logic [127:0] dec_t;

   always_comb begin
      dec_t = aes128_pkg::dec_sub(in_state) ^ dec_key;
      if (in_mode) begin
         state_in = last ? dec_t : aes128_pkg::inv_mix(dec_t);
      end else begin
         state_in = aes128_pkg::enc_round(in_state, last) ^ enc_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      mode_ff  <= in_mode;
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_mode  = mode_ff;
   assign out_state = state_ff;

   `ASSERT_NEXT(a_valid_follows, clock, reset, in_valid, out_valid)
   `ASSERT_NEXT(a_idle_follows, clock, reset, !in_valid, !out_valid)
   `ASSERT_NEXT(a_mode_carried, clock, reset, in_valid, out_mode == $past(in_mode))
endmodule
